// File: rtl/tes_pkg.sv
// Shared types and byte codes for the terminal escape stripper.
// No dependencies; every other file but tes_stream_if imports this package.
package tes_pkg;

    // Byte codes the parser reacts to
    localparam logic [7:0] BYTE_ESC  = 8'h1b;
    localparam logic [7:0] BYTE_DEL  = 8'h7f;
    localparam logic [7:0] BYTE_SP   = 8'h20;
    localparam logic [7:0] BYTE_BEL  = 8'h07;
    localparam logic [7:0] BYTE_LF   = 8'h0a;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_LBRK = 8'h5b;
    localparam logic [7:0] BYTE_RBRK = 8'h5d;
    localparam logic [7:0] BYTE_BSL  = 8'h5c;
    localparam logic [7:0] BYTE_LPAR = 8'h28;
    localparam logic [7:0] BYTE_RPAR = 8'h29;
    localparam logic [7:0] BYTE_HASH = 8'h23;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4,
        MODE_SKIP1   = 3'd5
    } mode_t;

    // One raw item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } item_t;

    // One classified item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       keep;
        logic       end_flag;
    } result_t;

endpackage

// File: rtl/tes_stream_if.sv
// Valid/ready channel interfaces for raw and classified items.
// Depends on nothing; payload fields follow tes_pkg item_t and result_t.
interface tes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface tes_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       keep;
    logic       end_flag;

    modport source (output valid, output out_byte, output keep, output end_flag, input ready);
    modport sink   (input valid, input out_byte, input keep, input end_flag, output ready);
endinterface

// File: rtl/tes_in_stage.sv
// Input register of the stripper: holds one raw item until it advances.
// Depends on tes_pkg and tes_stream_if.
module tes_in_stage
    import tes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tes_in_if.sink       raw,
    input  logic         advance,
    output logic         valid,
    output item_t        item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign raw.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (raw.valid && raw.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            item_reg.data_byte   <= raw.data_byte;
            item_reg.end_of_text <= raw.end_of_text;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: rtl/tes_classify.sv
// Escape parser: mode register plus keep decision for the held item.
// Depends on tes_pkg.
module tes_classify
    import tes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    mode_t mode_reg;
    mode_t mode_next;
    mode_t mode_step;
    logic  keep;
    logic  is_letter;
    logic  [7:0] c;

    assign c = item.data_byte;

    function automatic logic normal_keep(input logic [7:0] b);
        logic k;
        k = 1'b1;
        if (b == BYTE_ESC || b == BYTE_DEL)
        begin
            k = 1'b0;
        end
        else if (b < BYTE_SP && b != BYTE_LF && b != BYTE_TAB)
        begin
            k = 1'b0;
        end
        return k;
    endfunction

    function automatic mode_t normal_mode(input logic [7:0] b);
        return (b == BYTE_ESC) ? MODE_ESC : MODE_NORMAL;
    endfunction

    function automatic mode_t osc_mode(input logic [7:0] b);
        mode_t m;
        if (b == BYTE_BEL)
        begin
            m = MODE_NORMAL;
        end
        else if (b == BYTE_ESC)
        begin
            m = MODE_OSC_ESC;
        end
        else
        begin
            m = MODE_OSC;
        end
        return m;
    endfunction

    assign is_letter = c inside {[8'h41:8'h5a], [8'h61:8'h7a]};

    // Next mode from the current byte
    always_comb
    begin
        case (mode_reg)
            MODE_ESC:
            begin
                if (c == BYTE_LBRK)
                begin
                    mode_step = MODE_CSI;
                end
                else if (c == BYTE_RBRK)
                begin
                    mode_step = MODE_OSC;
                end
                else if (c inside {BYTE_LPAR, BYTE_RPAR, BYTE_HASH})
                begin
                    mode_step = MODE_SKIP1;
                end
                else
                begin
                    mode_step = normal_mode(c);
                end
            end
            MODE_CSI:     mode_step = is_letter ? MODE_NORMAL : MODE_CSI;
            MODE_OSC:     mode_step = osc_mode(c);
            MODE_OSC_ESC: mode_step = (c == BYTE_BSL) ? MODE_NORMAL : osc_mode(c);
            MODE_SKIP1:   mode_step = MODE_NORMAL;
            default:      mode_step = normal_mode(c);
        endcase
        mode_next = item.end_of_text ? MODE_NORMAL : mode_step;
    end

    // Keep decision: only normal text, or the byte after a lone ESC
    always_comb
    begin
        case (mode_reg)
            MODE_ESC:
            begin
                if (c inside {BYTE_LBRK, BYTE_RBRK, BYTE_LPAR, BYTE_RPAR, BYTE_HASH})
                begin
                    keep = 1'b0;
                end
                else
                begin
                    keep = normal_keep(c);
                end
            end
            MODE_CSI, MODE_OSC, MODE_OSC_ESC, MODE_SKIP1: keep = 1'b0;
            default:      keep = normal_keep(c);
        endcase
    end

    // Advance the mode with each item that moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
        end
    end

    assign result.out_byte = c;
    assign result.keep     = keep;
    assign result.end_flag = item.end_of_text;

`ifndef NO_ASSERTIONS
    a_eot_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.end_of_text |=> mode_reg == MODE_NORMAL)
        else $error("mode not normal after end of text");

    a_keep_only_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        advance && keep |-> (mode_reg == MODE_NORMAL || mode_reg == MODE_ESC))
        else $error("byte kept inside a sequence");

    a_no_kept_esc_del: assert property (@(posedge clk) disable iff (!rst_n)
        advance && keep |-> (c != BYTE_ESC && c != BYTE_DEL))
        else $error("ESC or DEL kept");
`endif

endmodule

// File: rtl/tes_out_stage.sv
// Result register of the stripper: holds one classified item for the sink.
// Depends on tes_pkg and tes_stream_if.
module tes_out_stage
    import tes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load_valid,
    input  result_t      result,
    output logic         load_ready,
    tes_out_if.source    clean
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Load when empty or when the held item leaves this cycle
    assign load_ready = !valid_reg || clean.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_valid && load_ready)
        begin
            valid_next = 1'b1;
        end
        else if (clean.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            result_reg <= result;
        end
    end

    assign clean.valid    = valid_reg;
    assign clean.out_byte = result_reg.out_byte;
    assign clean.keep     = result_reg.keep;
    assign clean.end_flag = result_reg.end_flag;

endmodule

// File: rtl/terminal_escape_stripper_unit.sv
// Top level of the terminal escape stripper: input register, parser, result register.
// Depends on tes_pkg, tes_stream_if, tes_in_stage, tes_classify, tes_out_stage.
//
//   channel  dir  payload                        handshake
//   raw      in   data_byte[7:0], end_of_text    valid/ready
//   clean    out  out_byte[7:0], keep, end_flag  valid/ready
//
// One item per cycle sustained while the sink is ready; an accepted item passes
// through the input register, then the result register, from which it can leave.
// The parser's mode register advances as an item moves into the result register.
// rst_n clears both valid bits and returns the parser to normal text.
// A stalled sink fills the result register, then the input register.
module terminal_escape_stripper_unit
    import tes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tes_in_if.sink    raw,
    tes_out_if.source clean
);

    logic    held_valid;
    item_t   held_item;
    logic    load_ready;
    logic    advance;
    result_t result;

    // Move the held item on when the result register can take it
    assign advance = held_valid && load_ready;

    tes_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw),
        .advance (advance),
        .valid   (held_valid),
        .item    (held_item)
    );

    tes_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (result)
    );

    tes_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .result     (result),
        .load_ready (load_ready),
        .clean      (clean)
    );

endmodule
